/* rtl/lcw80_pkg.sv */
// Shared types and constants for the LCW / Format80 decompressor.
// Used by the front decoder, the op queue and the back end. No dependencies.
`default_nettype none
package lcw80_pkg;

	// Widest history address; narrower configurations use the low bits
	localparam int unsigned ADDR_W = 16;

	// Sticky error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNWRITTEN = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_KIND      = 2'd3;

	// Item kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_CONT = 1'b1;

	// Command byte fields
	localparam logic [7:0] CMD_BIT7   = 8'h80;
	localparam logic [7:0] CMD_BIT6   = 8'h40;
	localparam logic [7:0] CNT_MASK   = 8'h3f;
	localparam logic [7:0] CNT_FILL   = 8'h3e;
	localparam logic [7:0] NIBBLE_MSK = 8'h0f;

	// One decoded beat handed from front to back
	typedef struct packed {
		logic              emit;     // writes history and shows a byte
		logic              use_mem;  // byte comes from history read
		logic [7:0]        byte_val; // byte when not read from history
		logic [ADDR_W-1:0] raddr;
		logic [ADDR_W-1:0] waddr;
		logic              want;
		logic              done;
		logic [1:0]        err;
	} op_t;

endpackage
`default_nettype wire

/* rtl/lcw80_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcw80_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/lcw80_front.sv */
// Front decoder: accepts items, walks the command state and emits one op per beat.
// Depends on lcw80_pkg.
`default_nettype none
module lcw80_front #(
	parameter int unsigned HISTORY_BYTES = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic          cmd,
	input  wire logic [7:0]    data_byte,
	output lcw80_pkg::op_t     op
);
	import lcw80_pkg::*;

	localparam int unsigned AW  = $clog2(HISTORY_BYTES);
	localparam int unsigned WPW = AW + 1;

	typedef enum logic [3:0] {
		PH_CMD, PH_SHORT, PH_LIT, PH_MED_LO, PH_MED_HI, PH_FCNT_LO, PH_FCNT_HI,
		PH_FVAL, PH_LCNT_LO, PH_LCNT_HI, PH_LPOS_LO, PH_LPOS_HI, PH_COPY,
		PH_FILL, PH_DONE
	} phase_t;

	phase_t          ph_q, ph_d;
	logic [WPW-1:0]  wp_q, wp_d;
	logic [15:0]     rem_q, rem_d;
	logic [15:0]     src_q, src_d;
	logic [7:0]      fill_q, fill_d;
	logic [1:0]      err_q, err_d;

	// Next-state decode for one item
	always_comb begin
		logic       cont;
		logic [7:0] b;
		logic       em;
		ph_d   = ph_q;
		wp_d   = wp_q;
		rem_d  = rem_q;
		src_d  = src_q;
		fill_d = fill_q;
		err_d  = err_q;
		cont   = (ph_q == PH_COPY) || (ph_q == PH_FILL);
		b      = 8'h00;
		em     = 1'b0;
		op          = '0;
		op.waddr    = ADDR_W'(wp_q[AW-1:0]);
		if (fire && ph_q != PH_DONE) begin
			if (cont != (cmd == CMD_CONT)) begin
				if (err_d == ERR_NONE) err_d = ERR_KIND;
			end else if (cont) begin
				if (ph_q == PH_FILL) begin
					b = fill_q;
				end else begin
					if ({1'b0, src_q} < 17'(wp_q)) begin
						op.use_mem = 1'b1;
						op.raddr   = src_q;
					end else if (err_d == ERR_NONE) begin
						err_d = ERR_UNWRITTEN;
					end
					src_d = src_q + 16'd1;
				end
				em    = 1'b1;
				rem_d = rem_q - 16'd1;
				if (rem_d == 16'd0) ph_d = PH_CMD;
			end else begin
				unique case (ph_q)
					PH_CMD: begin
						if ((data_byte & CMD_BIT7) == 8'h00) begin
							rem_d = 16'(data_byte[7:4]) + 16'd3;
							src_d = 16'(data_byte & NIBBLE_MSK);
							ph_d  = PH_SHORT;
						end else if ((data_byte & CMD_BIT6) == 8'h00) begin
							rem_d = 16'(data_byte & CNT_MASK);
							ph_d  = (rem_d == 16'd0) ? PH_DONE : PH_LIT;
						end else if ((data_byte & CNT_MASK) < CNT_FILL) begin
							rem_d = 16'(data_byte & CNT_MASK) + 16'd3;
							ph_d  = PH_MED_LO;
						end else if ((data_byte & CNT_MASK) == CNT_FILL) begin
							ph_d = PH_FCNT_LO;
						end else begin
							ph_d = PH_LCNT_LO;
						end
					end
					PH_SHORT: begin
						src_d = 16'(wp_q) - {4'h0, src_q[3:0], data_byte};
						ph_d  = PH_COPY;
					end
					PH_LIT: begin
						b     = data_byte;
						em    = 1'b1;
						rem_d = rem_q - 16'd1;
						if (rem_d == 16'd0) ph_d = PH_CMD;
					end
					PH_MED_LO: begin
						src_d = {8'h00, data_byte};
						ph_d  = PH_MED_HI;
					end
					PH_MED_HI: begin
						src_d = {data_byte, src_q[7:0]};
						ph_d  = PH_COPY;
					end
					PH_FCNT_LO: begin
						rem_d = {8'h00, data_byte};
						ph_d  = PH_FCNT_HI;
					end
					PH_FCNT_HI: begin
						rem_d = {data_byte, rem_q[7:0]};
						ph_d  = PH_FVAL;
					end
					PH_FVAL: begin
						fill_d = data_byte;
						ph_d   = (rem_q == 16'd0) ? PH_CMD : PH_FILL;
					end
					PH_LCNT_LO: begin
						rem_d = {8'h00, data_byte};
						ph_d  = PH_LCNT_HI;
					end
					PH_LCNT_HI: begin
						rem_d = {data_byte, rem_q[7:0]};
						ph_d  = PH_LPOS_LO;
					end
					PH_LPOS_LO: begin
						src_d = {8'h00, data_byte};
						ph_d  = PH_LPOS_HI;
					end
					PH_LPOS_HI: begin
						src_d = {data_byte, src_q[7:0]};
						ph_d  = (rem_q == 16'd0) ? PH_CMD : PH_COPY;
					end
					default: ph_d = PH_CMD;
				endcase
			end
			// Output store full: byte dropped, count still runs
			if (em) begin
				if (wp_q >= WPW'(HISTORY_BYTES)) begin
					if (err_d == ERR_NONE) err_d = ERR_OVERFLOW;
					op.use_mem = 1'b0;
				end else begin
					op.emit = 1'b1;
					wp_d    = wp_q + WPW'(1);
				end
			end
		end
		op.byte_val = b;
		op.want     = !((ph_d == PH_COPY) || (ph_d == PH_FILL));
		op.done     = (ph_d == PH_DONE);
		op.err      = err_d;
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_CMD;
			wp_q   <= '0;
			rem_q  <= '0;
			src_q  <= '0;
			fill_q <= '0;
			err_q  <= ERR_NONE;
		end else if (fire) begin
			ph_q   <= ph_d;
			wp_q   <= wp_d;
			rem_q  <= rem_d;
			src_q  <= src_d;
			fill_q <= fill_d;
			err_q  <= err_d;
		end
	end
endmodule
`default_nettype wire

/* rtl/lcw80_queue.sv */
// Two-entry op queue between the front decoder and the back end.
// Depends on lcw80_pkg.
`default_nettype none
module lcw80_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lcw80_pkg::op_t push_op,
	output logic                not_full,
	input  wire logic           pop,
	output logic                not_empty,
	output lcw80_pkg::op_t      head
);
	import lcw80_pkg::*;

	op_t        slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_op;
	end
endmodule
`default_nettype wire

/* rtl/lcw80_back.sv */
// Back end: history read, write-back with bypass, and the result register.
// Depends on lcw80_pkg and lcw80_ram.
`default_nettype none
module lcw80_back #(
	parameter int unsigned HISTORY_BYTES = 65536
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire lcw80_pkg::op_t q_op,
	output logic                q_pop,
	output logic                res_valid,
	input  wire logic           res_ready,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                want_data,
	output logic                done_res,
	output logic [1:0]          error_code
);
	import lcw80_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_BYTES);

	logic       v_s1;
	op_t        op_s1;
	logic       byp_s1;
	logic [7:0] bypd_s1;
	logic [7:0] rdata;
	logic [7:0] byte_now;
	logic       adv;
	logic       load;

	assign adv   = v_s1 && (!res_valid || res_ready);
	assign load  = q_valid && (!v_s1 || adv);
	assign q_pop = load;

	// Resolve the byte of the op in stage 1
	always_comb begin
		if (op_s1.use_mem) begin
			byte_now = byp_s1 ? bypd_s1 : rdata;
		end else begin
			byte_now = op_s1.byte_val;
		end
	end

	lcw80_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
		.clk   (clk),
		.we    (adv && op_s1.emit),
		.waddr (op_s1.waddr[AW-1:0]),
		.wdata (byte_now),
		.re    (load),
		.raddr (q_op.raddr[AW-1:0]),
		.rdata (rdata)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload; catch a read of the byte written this same cycle
	always_ff @(posedge clk) begin
		if (load) begin
			op_s1   <= q_op;
			byp_s1  <= adv && op_s1.emit && (q_op.raddr[AW-1:0] == op_s1.waddr[AW-1:0]);
			bypd_s1 <= byte_now;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte   <= op_s1.emit ? byte_now : 8'h00;
			out_valid  <= op_s1.emit;
			want_data  <= op_s1.want;
			done_res   <= op_s1.done;
			error_code <= op_s1.err;
		end
	end
endmodule
`default_nettype wire

/* rtl/lcw_format80_decompressor_unit.sv */
// LCW / Format80 decompressor top level: front decoder, op queue, back end.
// Throughput: one item per cycle (one history read and one history write per cycle).
// Path: each beat is registered in the queue slot, the history read and the result reg.
// Stalls: input stalls only when the two-entry queue fills under output backpressure.
// Reset (arst_n, async low) clears control and decode state; history needs no clearing.
// Depends on lcw80_pkg, lcw80_front, lcw80_queue, lcw80_back, lcw80_ram.
`default_nettype none
module lcw_format80_decompressor_unit #(
	parameter int unsigned HISTORY_BYTES = 65536
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       cmd,
	input  wire logic [7:0] data_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            want_data,
	output logic            done_res,
	output logic [1:0]      error_code
);
	import lcw80_pkg::*;

	op_t  f_op, q_head;
	logic fire, q_ne, q_pop;

	assign fire = in_valid && in_ready;

	lcw80_front #(.HISTORY_BYTES(HISTORY_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (cmd),
		.data_byte (data_byte),
		.op        (f_op)
	);

	lcw80_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_op   (f_op),
		.not_full  (in_ready),
		.pop       (q_pop),
		.not_empty (q_ne),
		.head      (q_head)
	);

	lcw80_back #(.HISTORY_BYTES(HISTORY_BYTES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_ne),
		.q_op       (q_head),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.want_data  (want_data),
		.done_res   (done_res),
		.error_code (error_code)
	);

`ifndef SYNTHESIS
	// A beat without a byte shows zero
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_byte == 8'h00))
		else $error("byte shown without out_valid");
	// End of stream persists
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && done_res) |=> (!res_valid || done_res))
		else $error("done_res dropped");
	// First error is held
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && error_code != ERR_NONE)
		|=> (!res_valid || error_code == $past(error_code)))
		else $error("error_code changed after latching");
`endif
endmodule
`default_nettype wire
